FILE: hw/rtl/mdhc_pkg.sv
package mdhc_pkg;

    localparam int MAX_DISPLAY = 64;
    localparam int MAX_SOURCE  = 4096;
    localparam int DISP_SHIFT  = $clog2(MAX_DISPLAY);

    localparam int SRC_W  = 13;
    localparam int POS_W  = 12;
    localparam int BIN_W  = 6;
    localparam int DISP_W = 7;
    localparam int IDX_W  = 2 * BIN_W;
    localparam int H_W    = 16;
    localparam int SUM_W  = 29;
    localparam int CNT_W  = 13;
    localparam int TOT_W  = 25;
    localparam int Q_W    = 30;
    localparam int P_W    = Q_W + CNT_W;
    localparam int N_W    = P_W + 10;
    localparam int COL_W  = 8;
    localparam int BIN_WORD_W = SUM_W + CNT_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 128;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_OUTSIDE    = 2'd2;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic [SRC_W-1:0] src_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [BIN_W-1:0] bin;
        logic             first;
        logic             last;
    } axis_stat_t;

    // Start of display bin k along an axis of source size s.
    function automatic logic [SRC_W-1:0] bin_bound(input logic [DISP_W-1:0] k,
                                                   input logic [SRC_W-1:0] s);
        logic [DISP_W+SRC_W-1:0] prod;
        prod = k * s;
        if (s > SRC_W'(MAX_DISPLAY)) begin
            bin_bound = SRC_W'(prod >> DISP_SHIFT);
        end else begin
            bin_bound = SRC_W'(k);
        end
    endfunction

    function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
        if (v == '0) begin
            clamp_src = SRC_W'(1);
        end else if (v > SRC_W'(MAX_SOURCE)) begin
            clamp_src = SRC_W'(MAX_SOURCE);
        end else begin
            clamp_src = v;
        end
    endfunction

    function automatic logic [DISP_W-1:0] disp_dim(input logic [SRC_W-1:0] s);
        if (s < SRC_W'(MAX_DISPLAY)) begin
            disp_dim = DISP_W'(s);
        end else begin
            disp_dim = DISP_W'(MAX_DISPLAY);
        end
    endfunction

endpackage

FILE: hw/rtl/masked_downsample_height_colormap_top.sv
// Height tile downsampler with a color ramp preview.
// Input stream: s_tuser selects the command. A load (s_tuser 0) carries one height
// sample and its valid flag in raster order; a read (s_tuser 1) asks for one
// display pixel. Only reads produce a transfer on the m_ channel.
// Loads are taken one per cycle while no read is at work. Each load reads its bin from
// the bin memory and writes the updated sum and count in the cycle after; a back-to-back
// load to the same bin takes the value just written from a bypass register.
// A read of a loaded bin fetches the bin and normalizes (RD_ADDR, RD_DATA, RD_NORM,
// RD_DEN), then for each of the three color channels sets up the operand (RD_NUM),
// starts the shared restoring divider (RD_DSTART) and waits while it forms 8 quotient
// bits (RD_DWAIT), then loads the output register and raises m_tvalid (RD_OUT).
// A read answered at once (frame not loaded or pixel outside the display) goes straight
// to RD_OUT, an empty bin after RD_DATA. s_tready is low while a read is at work.
// The result sits in an output register; a stalled receiver blocks only a read that
// finishes while the previous result is still waiting; loads flow while no read is at work.
// Configuration writes (cfg_wr_en) set the source size and restart the frame.
// Reset returns the source size to 1 x 1 and clears the frame statistics; bin
// contents are not cleared, since the first sample of each bin overwrites it.
module masked_downsample_height_colormap_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [12:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // height[15:0], valid_req[16], pixel_row[22:17], pixel_col[28:23], zero fill
    input  logic [31:0]  s_tdata,
    // cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // red[7:0], green[15:8], blue[23:16], status[25:24], min_height[41:26],
    // max_height[57:42], valid_total[82:58], invalid_total[107:83],
    // disp_cols[114:108], disp_rows[121:115], zero fill
    output logic [127:0] m_tdata
);
    import mdhc_pkg::*;

    typedef enum logic [8:0] {
        RD_IDLE   = 9'b000000001,
        RD_ADDR   = 9'b000000010,
        RD_DATA   = 9'b000000100,
        RD_NORM   = 9'b000001000,
        RD_DEN    = 9'b000010000,
        RD_NUM    = 9'b000100000,
        RD_DSTART = 9'b001000000,
        RD_DWAIT  = 9'b010000000,
        RD_OUT    = 9'b100000000
    } rd_state_t;

    // ---------------- configuration and frame statistics ----------------
    src_t               src_cols_reg, src_rows_reg;
    logic [DISP_W-1:0]  disp_cols, disp_rows;
    logic signed [H_W-1:0] low_reg, high_reg, low_next, high_next;
    logic [TOT_W-1:0]   vtot_reg, itot_reg, vtot_next, itot_next;
    logic               done_reg, done_next;

    rd_state_t          state_reg, state_next;
    axis_stat_t         col_stat, row_stat;

    logic               load_fire, read_fire;
    logic signed [H_W-1:0] in_height;
    logic               in_valid;
    logic [BIN_W-1:0]   in_prow, in_pcol;

    assign disp_cols = disp_dim(src_cols_reg);
    assign disp_rows = disp_dim(src_rows_reg);

    assign in_height = $signed(s_tdata[15:0]);
    assign in_valid  = s_tdata[16];
    assign in_prow   = s_tdata[22:17];
    assign in_pcol   = s_tdata[28:23];

    assign s_tready  = state_reg == RD_IDLE;
    assign load_fire = s_tvalid && s_tready && !s_tuser;
    assign read_fire = s_tvalid && s_tready && s_tuser;

    mdhc_axis u_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .src_size (src_cols_reg),
        .clear    (cfg_wr_en),
        .step     (load_fire),
        .stat     (col_stat)
    );

    mdhc_axis u_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .src_size (src_rows_reg),
        .clear    (cfg_wr_en),
        .step     (load_fire && col_stat.last),
        .stat     (row_stat)
    );

    always_comb begin
        logic [TOT_W-1:0] base_v;
        logic [TOT_W-1:0] base_i;
        base_v    = done_reg ? '0 : vtot_reg;
        base_i    = done_reg ? '0 : itot_reg;
        low_next  = low_reg;
        high_next = high_reg;
        vtot_next = vtot_reg;
        itot_next = itot_reg;
        done_next = done_reg;
        if (cfg_wr_en) begin
            low_next  = '0;
            high_next = '0;
            vtot_next = '0;
            itot_next = '0;
            done_next = 1'b0;
        end else if (load_fire) begin
            // A load after a complete frame starts a new one from cleared totals.
            if (done_reg) begin
                low_next  = '0;
                high_next = '0;
            end
            vtot_next = base_v;
            itot_next = base_i;
            if (in_valid) begin
                if (base_v == '0) begin
                    low_next  = in_height;
                    high_next = in_height;
                end else begin
                    if (in_height < low_reg) begin
                        low_next = in_height;
                    end
                    if (in_height > high_reg) begin
                        high_next = in_height;
                    end
                end
                vtot_next = base_v + TOT_W'(1);
            end else begin
                itot_next = base_i + TOT_W'(1);
            end
            done_next = col_stat.last && row_stat.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_cols_reg <= SRC_W'(1);
            src_rows_reg <= SRC_W'(1);
            low_reg      <= '0;
            high_reg     <= '0;
            vtot_reg     <= '0;
            itot_reg     <= '0;
            done_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_COLS: src_cols_reg <= clamp_src(cfg_wdata);
                    CFG_ROWS: src_rows_reg <= clamp_src(cfg_wdata);
                    default: ;
                endcase
            end
            low_reg  <= low_next;
            high_reg <= high_next;
            vtot_reg <= vtot_next;
            itot_reg <= itot_next;
            done_reg <= done_next;
        end
    end

    // ---------------- bin memory read-modify-write ----------------
    logic                   s1_valid_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic                   s1_first_reg;
    logic                   s1_vld_reg;
    logic signed [H_W-1:0]  s1_h_reg;
    logic                   wr_valid_reg;
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [BIN_WORD_W-1:0]  wr_data_reg;

    logic [BIN_W-1:0]       pr_reg, pc_reg;
    logic [IDX_W-1:0]       ram_raddr;
    logic [BIN_WORD_W-1:0]  ram_rdata, old_word, new_word;
    logic signed [SUM_W-1:0] old_sum, new_sum;
    logic [CNT_W-1:0]       old_cnt, new_cnt;

    assign ram_raddr = (state_reg == RD_ADDR) ? {pr_reg, pc_reg} : {row_stat.bin, col_stat.bin};

    always_comb begin
        old_word = (wr_valid_reg && wr_idx_reg == s1_idx_reg) ? wr_data_reg : ram_rdata;
        old_sum  = s1_first_reg ? '0 : $signed(old_word[SUM_W-1:0]);
        old_cnt  = s1_first_reg ? '0 : old_word[BIN_WORD_W-1:SUM_W];
        new_sum  = s1_vld_reg ? old_sum + SUM_W'(s1_h_reg) : old_sum;
        new_cnt  = s1_vld_reg ? old_cnt + CNT_W'(1) : old_cnt;
        new_word = {new_cnt, new_sum};
    end

    mdhc_ram #(
        .WIDTH (BIN_WORD_W),
        .DEPTH (MAX_DISPLAY * MAX_DISPLAY)
    ) u_bins (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (new_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= load_fire;
            wr_valid_reg <= s1_valid_reg;
        end
        s1_idx_reg   <= {row_stat.bin, col_stat.bin};
        s1_first_reg <= row_stat.first && col_stat.first;
        s1_vld_reg   <= in_valid;
        s1_h_reg     <= in_height;
        wr_idx_reg   <= s1_idx_reg;
        wr_data_reg  <= new_word;
    end

    // ---------------- pixel read sequencer ----------------
    logic [DISP_W-1:0]      rows_reg, cols_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic signed [Q_W-1:0]  lowcnt_reg;
    logic [Q_W-1:0]         qraw_reg, q_reg, ra_reg, ga_reg, ba_reg;
    logic [CNT_W-1:0]       tot_reg, tote_reg;
    logic [P_W-1:0]         den_reg, mag_reg, p_reg;
    logic [1:0]             ch_reg;
    logic [COL_W-1:0]       r_reg, g_reg, b_reg;
    logic [1:0]             st_reg;
    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    logic                   div_start, div_done;
    logic [N_W-1:0]         div_num, div_den;
    logic [COL_W-1:0]       div_quo;

    logic [SRC_W-1:0]       row_span, col_span;
    logic [DISP_W-1:0]      pr_ext, pc_ext;
    logic [H_W:0]           range;
    logic signed [Q_W:0]    norm_num;
    logic [Q_W-1:0]         norm_n, q_sel, twon_q;
    logic [Q_W:0]           twon;
    logic [Q_W-1:0]         a_sel;
    logic                   out_free;

    assign pr_ext   = DISP_W'(pr_reg);
    assign pc_ext   = DISP_W'(pc_reg);
    assign row_span = bin_bound(pr_ext + DISP_W'(1), src_rows_reg) - bin_bound(pr_ext, src_rows_reg);
    assign col_span = bin_bound(pc_ext + DISP_W'(1), src_cols_reg) - bin_bound(pc_ext, src_cols_reg);
    assign range    = (H_W+1)'(high_reg - low_reg);
    assign out_free = !m_valid_reg || m_tready;

    // Normalized mean and ramp, all scaled by q so the channels stay exact rationals.
    always_comb begin
        norm_num = (Q_W+1)'(sum_reg) - (Q_W+1)'(lowcnt_reg);
        if (high_reg == low_reg) begin
            q_sel  = Q_W'(2);
            norm_n = Q_W'(1);
        end else begin
            q_sel = qraw_reg;
            if (norm_num < 0) begin
                norm_n = '0;
            end else if ($unsigned(norm_num) > (Q_W+1)'(qraw_reg)) begin
                norm_n = qraw_reg;
            end else begin
                norm_n = norm_num[Q_W-1:0];
            end
        end
        twon   = {norm_n, 1'b0};
        twon_q = twon[Q_W-1:0];
    end

    always_comb begin
        case (ch_reg)
            CH_RED:   a_sel = ra_reg;
            CH_GREEN: a_sel = ga_reg;
            default:  a_sel = ba_reg;
        endcase
    end

    assign div_start = state_reg == RD_DSTART;
    assign div_num   = (N_W'(p_reg) << 9) - (N_W'(p_reg) << 1) + N_W'(den_reg);
    assign div_den   = N_W'(den_reg) << 1;

    mdhc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RD_IDLE: begin
                if (read_fire) begin
                    if (!done_reg || DISP_W'(in_prow) >= disp_rows
                        || DISP_W'(in_pcol) >= disp_cols) begin
                        state_next = RD_OUT;
                    end else begin
                        state_next = RD_ADDR;
                    end
                end
            end
            RD_ADDR:   state_next = RD_DATA;
            RD_DATA:   state_next = (ram_rdata[BIN_WORD_W-1:SUM_W] == '0) ? RD_OUT : RD_NORM;
            RD_NORM:   state_next = RD_DEN;
            RD_DEN:    state_next = RD_NUM;
            RD_NUM:    state_next = RD_DSTART;
            RD_DSTART: state_next = RD_DWAIT;
            RD_DWAIT: begin
                if (div_done) begin
                    state_next = (ch_reg == CH_BLUE) ? RD_OUT : RD_NUM;
                end
            end
            RD_OUT: begin
                if (out_free) begin
                    state_next = RD_IDLE;
                end
            end
            default: state_next = RD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= RD_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == RD_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            RD_IDLE: begin
                pr_reg <= in_prow;
                pc_reg <= in_pcol;
                r_reg  <= '0;
                g_reg  <= '0;
                b_reg  <= '0;
                ch_reg <= CH_RED;
                if (!done_reg) begin
                    st_reg <= ST_NOT_LOADED;
                end else if (DISP_W'(in_prow) >= disp_rows || DISP_W'(in_pcol) >= disp_cols) begin
                    st_reg <= ST_OUTSIDE;
                end else begin
                    st_reg <= ST_OK;
                end
            end
            RD_ADDR: begin
                rows_reg <= row_span[DISP_W-1:0];
                cols_reg <= col_span[DISP_W-1:0];
            end
            RD_DATA: begin
                sum_reg    <= $signed(ram_rdata[SUM_W-1:0]);
                cnt_reg    <= ram_rdata[BIN_WORD_W-1:SUM_W];
                lowcnt_reg <= Q_W'($signed(low_reg) * $signed({1'b0, ram_rdata[BIN_WORD_W-1:SUM_W]}));
                qraw_reg   <= Q_W'(ram_rdata[BIN_WORD_W-1:SUM_W] * range);
                tot_reg    <= CNT_W'(rows_reg * cols_reg);
                // An empty bin shows plain magenta.
                r_reg <= {COL_W{1'b1}};
                b_reg <= {COL_W{1'b1}};
            end
            RD_NORM: begin
                tote_reg <= (tot_reg < cnt_reg) ? cnt_reg : tot_reg;
                q_reg    <= q_sel;
                if (twon <= (Q_W+1)'(q_sel)) begin
                    ra_reg <= '0;
                    ga_reg <= twon_q;
                    ba_reg <= q_sel - twon_q;
                end else begin
                    ra_reg <= twon_q - q_sel;
                    ga_reg <= q_sel;
                    ba_reg <= '0;
                end
            end
            RD_DEN: begin
                den_reg <= P_W'(q_reg * tote_reg);
                mag_reg <= P_W'(q_reg * (tote_reg - cnt_reg));
            end
            RD_NUM: begin
                p_reg <= P_W'(a_sel * cnt_reg) + ((ch_reg == CH_GREEN) ? '0 : mag_reg);
            end
            RD_DWAIT: begin
                if (div_done) begin
                    case (ch_reg)
                        CH_RED:   r_reg <= div_quo;
                        CH_GREEN: g_reg <= div_quo;
                        default:  b_reg <= div_quo;
                    endcase
                    ch_reg <= ch_reg + 2'd1;
                end
            end
            RD_OUT: begin
                if (out_free) begin
                    m_data_reg <= {6'd0, disp_rows, disp_cols, itot_reg, vtot_reg,
                                   high_reg, low_reg, st_reg, b_reg, g_reg, r_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        read_fire |=> !s_tready)
        else $error("input accepted while a pixel read was in progress");

    a_no_rmw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == RD_ADDR |-> !s1_valid_reg)
        else $error("pixel read issued while a bin update was pending");

    a_status_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[25:24] != ST_OK |-> m_data_reg[23:0] == '0)
        else $error("non-ok status with a nonzero color");

    a_div_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == RD_DWAIT)
        else $error("divider finished outside its wait state");
endmodule

FILE: hw/rtl/mdhc_ram.sv
module mdhc_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/mdhc_axis.sv
module mdhc_axis (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mdhc_pkg::src_t         src_size,
    input  logic                   clear,
    input  logic                   step,
    output mdhc_pkg::axis_stat_t   stat
);
    import mdhc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [SRC_W-1:0] pos_inc;
    logic [SRC_W-1:0] next_bound;

    assign pos_inc    = SRC_W'(pos_reg) + SRC_W'(1);
    assign next_bound = bin_bound(DISP_W'(bin_reg) + DISP_W'(1), src_size);

    assign stat.pos   = pos_reg;
    assign stat.bin   = bin_reg;
    assign stat.first = SRC_W'(pos_reg) == bin_bound(DISP_W'(bin_reg), src_size);
    assign stat.last  = pos_inc >= src_size;

    always_comb begin
        pos_next = pos_reg;
        bin_next = bin_reg;
        if (clear) begin
            pos_next = '0;
            bin_next = '0;
        end else if (step) begin
            if (stat.last) begin
                pos_next = '0;
                bin_next = '0;
            end else begin
                pos_next = pos_inc[POS_W-1:0];
                // Crossing into the next bin happens when the position reaches its start.
                if (pos_inc == next_bound) begin
                    bin_next = bin_reg + BIN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            bin_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            bin_reg <= bin_next;
        end
    end
endmodule

FILE: hw/rtl/mdhc_div.sv
module mdhc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mdhc_pkg::N_W-1:0]   dividend,
    input  logic [mdhc_pkg::N_W-1:0]   divisor,
    output logic                       done,
    output logic [mdhc_pkg::COL_W-1:0] quotient
);
    import mdhc_pkg::*;

    localparam int STEP_W = $clog2(COL_W);

    logic [N_W-1:0]    rem_reg, rem_next;
    logic [N_W-1:0]    dv_reg, dv_next;
    logic [COL_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Restoring division, one quotient bit per cycle; the quotient never exceeds 8 bits.
    always_comb begin
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dv_next   = divisor << (COL_W - 1);
            quo_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= dv_reg) begin
                rem_next = rem_reg - dv_reg;
                quo_next = {quo_reg[COL_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[COL_W-2:0], 1'b0};
            end
            dv_next   = dv_reg >> 1;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(COL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        quo_reg <= quo_next;
    end
endmodule
